FILE: src/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

    localparam int CELLS  = 4096;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int DECAY_W = 16;
    localparam int HEAT_W  = 24;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 12;
    localparam int OP_W    = 3;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
    localparam logic [HEAT_W-1:0]  HEAT_ONE    = 24'h010000;
    localparam logic [HEAT_W-1:0]  HEAT_MAX    = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef logic [CELL_W-1:0] addr_t;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE  = 3'd0,
        OP_CONT  = 3'd1,
        OP_DEAD  = 3'd2,
        OP_ROUND = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] visits;
        logic [HEAT_W-1:0]  heat;
        logic               moved;
        logic [COUNT_W-1:0] cont;
        logic [COUNT_W-1:0] dead;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } ram_wr_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: src/chm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface chm_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [11:0] cell_index;

    modport source (output valid, output operation, output cell_index, input ready);
    modport sink   (input valid, input operation, input cell_index, output ready);
endinterface

interface chm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] total_visits_out;
    logic [23:0] decayed_heat_out;
    logic [31:0] contention_out;
    logic [31:0] deadlock_out;

    modport source (output valid, output total_visits_out, output decayed_heat_out,
                    output contention_out, output deadlock_out, input ready);
    modport sink   (input valid, input total_visits_out, input decayed_heat_out,
                    input contention_out, input deadlock_out, output ready);
endinterface

`default_nettype wire

FILE: src/chm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module chm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 121,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/chm_decay.sv
`timescale 1ns / 1ps
`default_nettype none

module chm_decay (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_valid,
    input  wire chm_pkg::addr_t                 rd_addr,
    input  wire chm_pkg::entry_t                rd_data,
    input  wire logic [chm_pkg::DECAY_W-1:0]    decay,
    output chm_pkg::ram_wr_t                    wr,
    output logic                                busy
);

    import chm_pkg::*;

    logic                        valid_reg;
    addr_t                       addr_reg;
    entry_t                      ent_reg;
    logic [HEAT_W+DECAY_W-1:0]   product_reg;

    logic [HEAT_W-1:0]           heat_dec;
    logic [HEAT_W:0]             heat_sum;
    entry_t                      ent_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid)
        begin
            addr_reg    <= rd_addr;
            ent_reg     <= rd_data;
            product_reg <= (HEAT_W + DECAY_W)'(rd_data.heat) * (HEAT_W + DECAY_W)'(decay);
        end
    end

    // truncate the Q8.16 x Q0.16 product back to Q8.16, then add the saturating round bonus to a moved cell
    always_comb
    begin
        heat_dec = product_reg[HEAT_W+DECAY_W-1:DECAY_W];
        heat_sum = {1'b0, heat_dec} + {1'b0, HEAT_ONE};
        ent_new  = ent_reg;
        ent_new.moved = 1'b0;
        if (ent_reg.moved)
        begin
            ent_new.heat = heat_sum[HEAT_W] ? HEAT_MAX : heat_sum[HEAT_W-1:0];
        end
        else
        begin
            ent_new.heat = heat_dec;
        end
        wr.en   = valid_reg;
        wr.addr = addr_reg;
        wr.data = ent_new;
        busy    = valid_reg;
    end

endmodule

`default_nettype wire

FILE: src/cell_heat_map_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                                              Handshake
// item      in    operation[2:0], cell_index[11:0]                     valid/ready
// result    out   total_visits_out, decayed_heat_out, contention_out,  valid/ready
//                 deadlock_out
// cfg       in    cfg_wr_data[15:0] (decay factor, Q0.16)              cfg_wr_en
//
// A move, contention, deadlock or read does one memory read, then the
// read-modify-write of the single cell entry (no write for a read) and the load of the result register.
// An end of round goes through the accept, one cell read per cycle through
// the decay multiplier pipeline, a drain, then the read of the addressed cell.
// After reset a clearing pass writes zero to all CELLS entries;
// no item is taken meanwhile. A stalled result holds the block in the write-back step.

module cell_heat_map_tracker_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    chm_item_if.sink                            item,
    chm_result_if.source                        result,
    input  wire logic                           cfg_wr_en,
    input  wire logic [chm_pkg::DECAY_W-1:0]    cfg_wr_data
);

    import chm_pkg::*;

    state_t                 state_reg, state_next;
    addr_t                  cnt_reg, cnt_next;
    logic                   sweep_pend_reg, sweep_pend_next;
    logic [OP_W-1:0]        op_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [DECAY_W-1:0]     decay_reg;
    logic                   out_valid_reg, out_valid_next;
    entry_t                 out_reg, out_next;

    logic                   accept;
    logic                   cnt_last;
    logic                   idx_ok;
    logic                   access_go;
    logic                   rd_en;
    addr_t                  rd_addr;
    logic [ENTRY_W-1:0]     rd_word;
    entry_t                 rd_entry;
    entry_t                 upd_entry;
    logic                   upd_we;
    ram_wr_t                dec_wr;
    ram_wr_t                mem_wr;
    logic                   dec_busy;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == ST_IDLE);
    assign cnt_last    = (cnt_reg == addr_t'(CELLS - 1));
    assign idx_ok      = (32'(idx_reg) < 32'(CELLS));
    assign access_go   = !out_valid_reg || result.ready;
    assign rd_entry    = entry_t'(rd_word);

    assign result.valid            = out_valid_reg;
    assign result.total_visits_out = out_reg.visits;
    assign result.decayed_heat_out = out_reg.heat;
    assign result.contention_out   = out_reg.cont;
    assign result.deadlock_out     = out_reg.dead;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            decay_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            sweep_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sweep_pend_reg <= sweep_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= item.operation;
            idx_reg <= item.cell_index;
        end
        out_reg <= out_next;
    end

    // apply a counter event to the entry just read
    always_comb
    begin
        upd_entry = rd_entry;
        upd_we    = 1'b0;
        case (op_reg)
            OP_MOVE:
            begin
                upd_entry.visits = sat_inc(rd_entry.visits);
                upd_entry.moved  = 1'b1;
                upd_we           = idx_ok;
            end
            OP_CONT:
            begin
                upd_entry.cont = sat_inc(rd_entry.cont);
                upd_we         = idx_ok;
            end
            OP_DEAD:
            begin
                upd_entry.dead = sat_inc(rd_entry.dead);
                upd_we         = idx_ok;
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sweep_pend_next = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = addr_t'(item.cell_index);
        mem_wr.en       = 1'b0;
        mem_wr.addr     = cnt_reg;
        mem_wr.data     = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.en = 1'b1;
                cnt_next  = cnt_reg + addr_t'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.operation == OP_ROUND)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS:
            begin
                if (access_go)
                begin
                    mem_wr.en      = upd_we;
                    mem_wr.addr    = addr_t'(idx_reg);
                    mem_wr.data    = upd_entry;
                    out_valid_next = 1'b1;
                    out_next       = idx_ok ? upd_entry : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                rd_en           = 1'b1;
                rd_addr         = cnt_reg;
                sweep_pend_next = 1'b1;
                cnt_next        = cnt_reg + addr_t'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last decayed entry to land, then read the addressed cell
                if (!sweep_pend_reg && !dec_busy)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_t'(idx_reg);
                    state_next = ST_ACCESS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (dec_wr.en)
        begin
            mem_wr = dec_wr;
        end
    end

    chm_ram #(
        .DEPTH (CELLS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    chm_decay u_decay (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (sweep_pend_reg),
        .rd_addr  (cnt_reg - addr_t'(1)),
        .rd_data  (rd_entry),
        .decay    (decay_reg),
        .wr       (dec_wr),
        .busy     (dec_busy)
    );

    a_decay_wr_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        dec_wr.en |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("decay write outside end-of-round sweep");

    a_access_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) |-> (!sweep_pend_reg && !dec_busy))
        else $error("cell access while sweep pipeline busy");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("cell counter not rewound");

    a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ACCESS || state_reg == ST_SWEEP))
        else $error("accepted transaction not processed");

endmodule

`default_nettype wire

FILE: tb/cell_heat_map_tracker_core_test.sv
`timescale 1ns / 1ps

module cell_heat_map_tracker_core_test;

    import chm_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASE_ITEMS = 60;
    localparam int SAT_ROUNDS = 40;
    localparam logic [INDEX_W-1:0] CELL_LAST = INDEX_W'(CELLS - 1);
    localparam logic [INDEX_W-1:0] SAT_CELL  = 12'h7FF;

    // Unused operation codes; the block treats them as a read.
    localparam logic [OP_W-1:0] OP_RSV5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSV6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSV7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    code;
        logic [INDEX_W-1:0] pos;
    } event_t;

    typedef struct packed {
        logic [COUNT_W-1:0] visits;
        logic [HEAT_W-1:0]  heat;
        logic [COUNT_W-1:0] cont;
        logic [COUNT_W-1:0] dead;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [DECAY_W-1:0] cfg_wr_data;

    chm_item_if   item_ch ();
    chm_result_if result_ch ();

    cell_heat_map_tracker_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the cell statistics
    logic [COUNT_W-1:0] visits_m [CELLS];
    logic [HEAT_W-1:0]  heat_m   [CELLS];
    logic               moved_m  [CELLS];
    logic [COUNT_W-1:0] cont_m   [CELLS];
    logic [COUNT_W-1:0] dead_m   [CELLS];
    logic [DECAY_W-1:0] decay_q;

    event_t pending_events [$];
    stats_t expected_stats [$];
    logic [INDEX_W-1:0] hot_cells [8];

    int idle_pct;
    int mismatches;
    int items_taken;
    int results_seen;
    int sweeps_taken;
    int decay_settings;
    int quiet_cycles;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void sweep_cells();
        logic [47:0] prod;
        logic [24:0] acc;
        for (int i = 0; i < CELLS; i++)
        begin
            prod = heat_m[i] * decay_q;
            acc  = {1'b0, prod[39:16]};
            if (moved_m[i])
            begin
                acc = acc + HEAT_ONE;
                if (acc > HEAT_MAX)
                    acc = HEAT_MAX;
            end
            heat_m[i]  = acc[HEAT_W-1:0];
            moved_m[i] = 1'b0;
        end
    endfunction

    function automatic stats_t apply_event(input logic [OP_W-1:0] code,
                                           input logic [INDEX_W-1:0] pos);
        stats_t s;
        if (code == OP_ROUND)
            sweep_cells();
        else if (code == OP_MOVE)
        begin
            visits_m[pos] = bump(visits_m[pos]);
            moved_m[pos]  = 1'b1;
        end
        else if (code == OP_CONT)
            cont_m[pos] = bump(cont_m[pos]);
        else if (code == OP_DEAD)
            dead_m[pos] = bump(dead_m[pos]);
        s.visits = visits_m[pos];
        s.heat   = heat_m[pos];
        s.cont   = cont_m[pos];
        s.dead   = dead_m[pos];
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns  mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_event(input logic [OP_W-1:0] code, input logic [INDEX_W-1:0] pos);
        event_t ev;
        ev.code = code;
        ev.pos  = pos;
        pending_events.insert(pending_events.size(), ev);
    endtask

    function automatic event_t random_event();
        event_t ev;
        int pick;
        pick = $urandom_range(99);
        if (pick < 34)
            ev.code = OP_MOVE;
        else if (pick < 50)
            ev.code = OP_CONT;
        else if (pick < 64)
            ev.code = OP_DEAD;
        else if (pick < 84)
            ev.code = OP_READ;
        else if (pick < 89)
            ev.code = OP_W'(OP_RSV5 + $urandom_range(2));
        else if (pick < 95)
            ev.code = OP_MOVE;
        else
            ev.code = OP_ROUND;
        // Concentrate on a few cells so counts and heat build up
        if ($urandom_range(99) < 70)
            ev.pos = hot_cells[$urandom_range(7)];
        else
            ev.pos = INDEX_W'($urandom_range(CELLS - 1));
        return ev;
    endfunction

    task automatic write_decay(input logic [DECAY_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        decay_q = value;
        decay_settings++;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        // sample at the falling edge, once the driver and monitor have settled
        do
            @(negedge clk);
        while (pending_events.size() != 0 || item_ch.valid || expected_stats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Item driver: hold a transaction until it is taken, then advance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.operation  <= OP_READ;
            item_ch.cell_index <= '0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item_ch.valid      <= 1'b1;
                item_ch.operation  <= pending_events[0].code;
                item_ch.cell_index <= pending_events[0].pos;
                void'(pending_events.pop_front());
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        stats_t want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_stats.insert(expected_stats.size(),
                                      apply_event(item_ch.operation, item_ch.cell_index));
                items_taken++;
                if (item_ch.operation == OP_ROUND)
                    sweeps_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_stats.size() == 0)
                    flag_mismatch("result with no transaction pending",
                                  result_ch.total_visits_out, '0);
                else
                begin
                    want = expected_stats.pop_front();
                    if (result_ch.total_visits_out !== want.visits)
                        flag_mismatch("total_visits_out", result_ch.total_visits_out,
                                      want.visits);
                    if (result_ch.decayed_heat_out !== want.heat)
                        flag_mismatch("decayed_heat_out", 32'(result_ch.decayed_heat_out),
                                      32'(want.heat));
                    if (result_ch.contention_out !== want.cont)
                        flag_mismatch("contention_out", result_ch.contention_out, want.cont);
                    if (result_ch.deadlock_out !== want.dead)
                        flag_mismatch("deadlock_out", result_ch.deadlock_out, want.dead);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("cell_heat_map_tracker_core_test: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [DECAY_W-1:0] phase_decay [5];
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_READ;
        item_ch.cell_index = '0;
        result_ch.ready    = 1'b0;
        idle_pct           = 20;
        mismatches         = 0;
        items_taken        = 0;
        results_seen       = 0;
        sweeps_taken       = 0;
        decay_settings     = 0;
        quiet_cycles       = 0;
        decay_q            = DECAY_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            visits_m[i] = '0;
            heat_m[i]   = '0;
            moved_m[i]  = 1'b0;
            cont_m[i]   = '0;
            dead_m[i]   = '0;
        end
        hot_cells[0] = '0;
        hot_cells[1] = CELL_LAST;
        for (int i = 2; i < 8; i++)
            hot_cells[i] = INDEX_W'($urandom_range(CELLS - 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, running on the reset decay factor
        queue_event(OP_MOVE, '0);
        queue_event(OP_MOVE, '0);          // second move in one round: mark stays single
        queue_event(OP_MOVE, CELL_LAST);
        queue_event(OP_CONT, CELL_LAST);
        queue_event(OP_DEAD, '0);
        queue_event(OP_DEAD, CELL_LAST);
        queue_event(OP_CONT, 12'hAAA);
        queue_event(OP_MOVE, 12'h555);
        queue_event(OP_READ, '0);
        queue_event(OP_RSV5, 12'hAAA);
        queue_event(OP_RSV6, 12'h555);
        queue_event(OP_RSV7, CELL_LAST);
        queue_event(OP_ROUND, '0);
        queue_event(OP_READ, CELL_LAST);
        queue_event(OP_READ, 12'h555);
        queue_event(OP_ROUND, CELL_LAST);
        queue_event(OP_MOVE, '0);
        queue_event(OP_ROUND, 12'h555);
        queue_event(OP_READ, '0);
        queue_event(OP_RSV7, '0);
        wait_drained();

        phase_decay[0] = '0;
        phase_decay[1] = '1;
        phase_decay[2] = 16'h8000;
        phase_decay[3] = DECAY_W'($urandom_range(65535));
        phase_decay[4] = 16'h0001;
        for (int p = 0; p < 5; p++)
        begin
            write_decay(phase_decay[p]);
            // one phase runs with no idling on either side
            idle_pct = (p == 2) ? 0 : 20;
            for (int n = 0; n < RAND_PHASE_ITEMS; n++)
                pending_events.insert(pending_events.size(), random_event());
            wait_drained();
        end
        idle_pct = 20;

        // Build up one cell's heat over many rounds with the slowest decay
        write_decay('1);
        for (int n = 0; n < SAT_ROUNDS; n++)
        begin
            queue_event(OP_MOVE, SAT_CELL);
            queue_event(OP_ROUND, SAT_CELL);
        end
        queue_event(OP_READ, SAT_CELL);
        wait_drained();

        if (expected_stats.size() != 0)
            flag_mismatch("results never delivered", expected_stats.size(), '0);
        $display("covered %0d transactions, %0d of them end-of-round sweeps,",
                 items_taken, sweeps_taken);
        $display("over %0d decay settings; checked %0d results, %0d mismatches",
                 decay_settings + 1, results_seen, mismatches);
        if (mismatches == 0)
            $display("cell_heat_map_tracker_core_test: clean");
        else
            $display("cell_heat_map_tracker_core_test: errors");
        $finish;
    end

endmodule
